/* src/bis_pkg.sv */
// Shared types, constants and helpers for the byte insertion sorter.
// Used by the front queue, the insertion row and the top level.
package bis_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned QUEUE_DEP = 4;
    localparam int unsigned QUEUE_AW  = 2;

    // Register index, taken from paddr[2]
    localparam logic REG_SIGNED_CMP = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] item_byte;
        logic              end_of_string;
        logic              signed_compare;
    } t_queue_entry;

    // Key whose unsigned order is the selected compare order
    function automatic logic [BYTE_W-1:0] order_key(input logic [BYTE_W-1:0] b,
                                                    input logic              s);
        order_key = s ? (b ^ 8'h80) : b;
    endfunction

endpackage

/* src/bis_in_if.sv */
// Input channel of the byte insertion sorter: one string byte per beat.
// Depends on bis_pkg for the byte width.
interface bis_in_if import bis_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] item_byte;
    logic              end_of_string;

    modport source (output valid, output item_byte, output end_of_string, input ready);
    modport sink   (input valid, input item_byte, input end_of_string, output ready);
endinterface

/* src/bis_out_if.sv */
// Output channel of the byte insertion sorter: one sorted byte per beat.
// Depends on bis_pkg for the byte width.
interface bis_out_if import bis_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] sorted_byte;
    logic              run_last;
    logic              overflow;

    modport source (output valid, output sorted_byte, output run_last, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_byte, input run_last, input overflow,
                    output ready);
endinterface

/* src/byte_insertion_sorter_top.sv */
// Top level of the byte insertion sorter: APB register, front queue and
// insertion row. Depends on bis_pkg, bis_in_if, bis_out_if, bis_front, bis_back.
//
// Usage:
//   i_in carries one string byte per beat with end_of_string on the final
//   byte. Each byte is inserted into a sorted row of MAX_LEN cells, stable for
//   equal bytes. On the marked byte the whole run leaves on o_out in
//   ascending order, one byte per beat, run_last on the final one and
//   overflow set on every beat if bytes past MAX_LEN were dropped.
//   The compare-and-shift row inserts one byte per cycle while it is not
//   draining; each accepted beat is first written into a four-entry queue
//   and is inserted from there. Draining moves one stored byte per cycle out
//   of cell 0 unless the receiver stalls; the first sorted beat is loaded
//   into the output register once the marked byte is inserted. The queue
//   keeps taking input while the row drains, until it is full.
//   A stalled receiver holds the output register and freezes the drain.
//   Reset empties the queue and the row and sets signed_compare to 1.
//   Register 0 (address 0): bit 0 signed_compare, 1 = two's complement.
module byte_insertion_sorter_top import bis_pkg::*; #(
    parameter int unsigned MAX_LEN = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bis_in_if.sink            i_in,
    bis_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic         r_signed_compare;
    logic         q_valid;
    logic         q_pop;
    t_queue_entry q_entry;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SIGNED_CMP) ? {{(APB_DW-1){1'b0}}, r_signed_compare}
                                                 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_compare <= 1'b1;
        end else if (psel && penable && pwrite && paddr[2] == REG_SIGNED_CMP) begin
            r_signed_compare <= pwdata[0];
        end
    end

    bis_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_signed_compare (r_signed_compare),
        .i_in             (i_in),
        .o_q_valid        (q_valid),
        .o_q_entry        (q_entry),
        .i_q_pop          (q_pop)
    );

    bis_back #(.MAX_LEN(MAX_LEN)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

/* src/bis_front.sv */
// Front end: accepts input beats, tags them with the compare mode in force
// and holds them in a short queue for the insertion row. Uses bis_pkg.
module bis_front import bis_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_signed_compare,
    bis_in_if.sink       i_in,
    output logic         o_q_valid,
    output t_queue_entry o_q_entry,
    input  logic         i_q_pop
);

    t_queue_entry          r_mem [QUEUE_DEP];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]     r_fill,   n_fill;
    logic                  push;
    logic                  pop;

    assign i_in.ready = (r_fill != (QUEUE_AW+1)'(QUEUE_DEP));
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_valid  = (r_fill != '0);
    assign o_q_entry  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + QUEUE_AW'(1) : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + QUEUE_AW'(1) : r_rd_ptr;
        n_fill   = r_fill;
        case ({push, pop})
            2'b10:   n_fill = r_fill + (QUEUE_AW+1)'(1);
            2'b01:   n_fill = r_fill - (QUEUE_AW+1)'(1);
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{item_byte:      i_in.item_byte,
                                 end_of_string:  i_in.end_of_string,
                                 signed_compare: i_signed_compare};
        end
    end

endmodule

/* src/bis_back.sv */
// Back end: a row of compare-and-shift cells that inserts one byte per
// cycle, then shifts the run out through an output register. Uses bis_pkg.
module bis_back import bis_pkg::*; #(
    parameter int unsigned MAX_LEN = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_queue_entry i_q_entry,
    output logic         o_q_pop,
    bis_out_if.source    o_out
);

    localparam int unsigned CW = $clog2(MAX_LEN + 1);

    logic [BYTE_W-1:0] r_cell [MAX_LEN];
    logic [BYTE_W-1:0] n_cell [MAX_LEN];
    logic [MAX_LEN-1:0] gt;
    logic [CW-1:0]     r_count;
    logic              r_dropped;
    logic              r_draining;
    logic              r_ov;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              r_out_ovf;
    logic              full;
    logic              do_insert;
    logic              out_load;
    logic [BYTE_W-1:0] new_key;

    assign o_q_pop   = i_q_valid && !r_draining;
    assign full      = (r_count == CW'(MAX_LEN));
    assign do_insert = o_q_pop && !full;
    assign out_load  = r_draining && (!r_ov || o_out.ready);
    assign new_key   = order_key(i_q_entry.item_byte, i_q_entry.signed_compare);

    for (genvar gi = 0; gi < MAX_LEN; gi++) begin : g_cell
        // Cell holds a stored byte strictly greater than the new one
        assign gt[gi] = (CW'(gi) < r_count) &&
                        (order_key(r_cell[gi], i_q_entry.signed_compare) > new_key);

        always_comb begin
            n_cell[gi] = r_cell[gi];
            if (do_insert) begin
                if (gi > 0 && gt[(gi > 0) ? gi - 1 : 0]) begin
                    n_cell[gi] = r_cell[(gi > 0) ? gi - 1 : 0];
                end else if (gt[gi] || CW'(gi) == r_count) begin
                    n_cell[gi] = i_q_entry.item_byte;
                end
            end else if (out_load) begin
                // advance the run towards cell 0
                n_cell[gi] = r_cell[(gi + 1 < MAX_LEN) ? gi + 1 : gi];
            end
        end

        always_ff @(posedge i_clk) begin
            r_cell[gi] <= n_cell[gi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_dropped  <= 1'b0;
            r_draining <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (o_q_pop) begin
                if (full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
                if (i_q_entry.end_of_string) begin
                    r_draining <= 1'b1;
                end
            end else if (out_load) begin
                r_count <= r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    r_draining <= 1'b0;
                    r_dropped  <= 1'b0;
                end
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= r_cell[0];
            r_out_last <= (r_count == CW'(1));
            r_out_ovf  <= r_dropped;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.sorted_byte = r_out_byte;
    assign o_out.run_last    = r_out_last;
    assign o_out.overflow    = r_out_ovf;

endmodule

/* verif/byte_insertion_sorter_top_test.sv */
// Self-checking test of byte_insertion_sorter_top: random strings go in one byte per beat,
// and every sorted beat is checked against a stable insertion sort kept alongside.
// Depends on bis_pkg, bis_in_if, bis_out_if and the RTL of the top level.
module byte_insertion_sorter_top_test;
    import bis_pkg::*;

    localparam int unsigned RUN_CAP     = 32;
    localparam int unsigned CLK_PERIOD  = 20;
    localparam int unsigned ITEM_TARGET = 370;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned SETTLE_CYC  = 2 * RUN_CAP + 10;
    localparam int unsigned HOLD_CYC    = 400;

    localparam logic [APB_AW-1:0] ADDR_SIGNED_CMP = {REG_SIGNED_CMP, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED   = {~REG_SIGNED_CMP, 2'b00};

    // Byte mixes for random strings
    localparam int unsigned MIX_ANY       = 0;
    localparam int unsigned MIX_NEAR_SIGN = 1;
    localparam int unsigned MIX_EXTREMES  = 2;

    typedef struct {
        logic [BYTE_W-1:0] item_byte;
        logic              end_of_string;
    } t_string_beat;

    typedef struct {
        logic [BYTE_W-1:0] sorted_byte;
        logic              run_last;
        logic              overflow;
    } t_sorted_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bis_in_if  in_ch ();
    bis_out_if out_ch ();

    byte_insertion_sorter_top #(.MAX_LEN(RUN_CAP)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the sorter: store, fill level, drop flag and compare mode
    logic [BYTE_W-1:0] run_store [RUN_CAP];
    int unsigned       run_fill = 0;
    bit                run_dropped = 1'b0;
    bit                cmp_signed = 1'b1;

    t_string_beat outgoing_bytes [$];
    t_sorted_beat sorted_beats_due [$];
    t_string_beat next_beat;

    int unsigned items_queued = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    bit          in_beat_taken = 1'b0;
    bit          tx_gappy = 1'b1;
    bit          rx_gappy = 1'b1;
    bit          hold_off = 1'b0;
    int unsigned tx_gap_left = 0;
    int unsigned rx_stall_left = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.item_byte = '0;
        in_ch.end_of_string = 1'b0;
        out_ch.ready = 1'b0;
    end

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got 'h%0h, want 'h%0h", cycle_count, what, got,
                 want);
        error_count++;
    endtask

    // Stable insertion: walk down past every stored byte strictly greater than the new one
    task automatic absorb_byte(input logic [BYTE_W-1:0] b, input logic eos);
        int unsigned       pos;
        logic [BYTE_W-1:0] new_key;
        logic [BYTE_W-1:0] old_key;
        if (run_fill >= RUN_CAP) begin
            run_dropped = 1'b1;
        end else begin
            pos = run_fill;
            new_key = {b[BYTE_W-1] ^ cmp_signed, b[BYTE_W-2:0]};
            while (pos > 0) begin
                old_key = {run_store[pos-1][BYTE_W-1] ^ cmp_signed, run_store[pos-1][BYTE_W-2:0]};
                if (new_key >= old_key) break;
                run_store[pos] = run_store[pos-1];
                pos--;
            end
            run_store[pos] = b;
            run_fill++;
        end
        if (eos) begin
            for (int unsigned k = 0; k < run_fill; k++) begin
                sorted_beats_due.push_back('{sorted_byte: run_store[k],
                                             run_last: (k + 1 == run_fill),
                                             overflow: run_dropped});
            end
            run_fill = 0;
            run_dropped = 1'b0;
        end
    endtask

    // Input side: predict on every accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            absorb_byte(in_ch.item_byte, in_ch.end_of_string);
            in_beat_taken = 1'b1;
        end
    end

    // Output side: check every accepted beat against the oldest expectation
    always @(posedge i_clk) begin
        t_sorted_beat due;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (sorted_beats_due.size() == 0) begin
                report_mismatch("unexpected beat, sorted_byte", 32'(out_ch.sorted_byte), 32'd0);
            end else begin
                due = sorted_beats_due.pop_front();
                if (out_ch.sorted_byte !== due.sorted_byte)
                    report_mismatch("sorted_byte", 32'(out_ch.sorted_byte),
                                    32'(due.sorted_byte));
                if (out_ch.run_last !== due.run_last)
                    report_mismatch("run_last", 32'(out_ch.run_last), 32'(due.run_last));
                if (out_ch.overflow !== due.overflow)
                    report_mismatch("overflow", 32'(out_ch.overflow), 32'(due.overflow));
            end
        end
    end

    // Sender: advance to the next byte once the current one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_beat_taken) begin
            in_beat_taken = 1'b0;
            if (tx_gap_left > 0) begin
                in_ch.valid <= 1'b0;
                tx_gap_left--;
            end else if (outgoing_bytes.size() > 0) begin
                next_beat = outgoing_bytes.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.item_byte <= next_beat.item_byte;
                in_ch.end_of_string <= next_beat.end_of_string;
                if (tx_gappy && $urandom_range(0, 99) < 25)
                    tx_gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                              : $urandom_range(1, 3);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus the long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            out_ch.ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            out_ch.ready <= 1'b0;
            rx_stall_left--;
        end else begin
            out_ch.ready <= 1'b1;
            if (rx_gappy && $urandom_range(0, 99) < 20)
                rx_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                            : $urandom_range(1, 3);
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eos);
        outgoing_bytes.push_back('{item_byte: b, end_of_string: eos});
        items_queued++;
    endtask

    task automatic push_string(input int unsigned str_len, input int unsigned mix);
        logic [BYTE_W-1:0] b;
        for (int unsigned i = 0; i < str_len; i++) begin
            case (mix)
                MIX_NEAR_SIGN: begin
                    b = 8'h7C + BYTE_W'($urandom_range(0, 7));
                end
                MIX_EXTREMES: begin
                    case ($urandom_range(0, 3))
                        0: b = 8'h00;
                        1: b = 8'h7F;
                        2: b = 8'h80;
                        default: b = 8'hFF;
                    endcase
                end
                default: begin
                    b = BYTE_W'($urandom_range(0, 255));
                end
            endcase
            push_byte(b, i + 1 == str_len);
        end
    endtask

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 10);
        if (r < 88) return $urandom_range(11, RUN_CAP - 1);
        if (r < 95) return $urandom_range(RUN_CAP - 1, RUN_CAP + 1);
        return $urandom_range(RUN_CAP + 2, RUN_CAP + 13);
    endfunction

    // Wait until every byte is sent and every sorted beat has come back
    task automatic wait_idle();
        @(posedge i_clk);
        while (outgoing_bytes.size() != 0 || in_ch.valid || sorted_beats_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic check_compare_mode();
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_SIGNED_CMP;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[0] !== cmp_signed)
            report_mismatch("signed_compare readback", 32'(prdata[0]), 32'(cmp_signed));
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic write_compare_mode(input logic [APB_AW-1:0] addr,
                                      input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        // Only bit 0 of the one register counts
        if (addr == ADDR_SIGNED_CMP)
            cmp_signed = value[0];
        check_compare_mode();
    endtask

    task automatic push_extremes_string();
        push_byte(8'h7F, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h81, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b1);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        check_compare_mode();

        // Directed: one-byte string, sign-boundary extremes with repeats, all-bits pair
        push_byte(8'h00, 1'b1);
        push_extremes_string();
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b1);
        wait_idle();
        write_compare_mode(ADDR_SIGNED_CMP, 32'hFFFF_FFFE);
        write_compare_mode(ADDR_UNMAPPED, 32'h0000_0001);
        push_extremes_string();
        wait_idle();
        write_compare_mode(ADDR_SIGNED_CMP, 32'h0000_0001);

        // Hold the receiver off while strings keep coming, so the input backs up
        tx_gappy = 1'b0;
        rx_gappy = 1'b0;
        hold_off = 1'b1;
        push_string(20, MIX_ANY);
        push_string(20, MIX_NEAR_SIGN);
        push_string(12, MIX_ANY);
        repeat (HOLD_CYC) @(posedge i_clk);
        hold_off = 1'b0;

        while (items_queued < ITEM_TARGET) begin
            wait_idle();
            write_compare_mode(ADDR_SIGNED_CMP, $urandom);
            tx_gappy = ($urandom_range(0, 3) != 0);
            rx_gappy = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 4)) push_string(pick_length(), $urandom_range(0, 2));
        end

        wait_idle();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
src/bis_pkg.sv
src/bis_in_if.sv
src/bis_out_if.sv
src/bis_front.sv
src/bis_back.sv
src/byte_insertion_sorter_top.sv
verif/byte_insertion_sorter_top_test.sv
